// ===== hdl/lpc_pkg.sv =====
`timescale 1ns / 1ps

package lpc_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FRACTION_BITS_DEF = 4;
	localparam int SENSOR_COUNT      = 8;
	localparam int PAIR_COUNT        = SENSOR_COUNT / 2;
	localparam int THRESH_BITS       = 12;
	localparam int POS_BITS          = 14;
	// centroid magnitude never exceeds the outer weight 350, below 2^9
	localparam int QUOT_INT_BITS     = 9;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2048;

	typedef struct packed {
		logic full;
		logic empty;
	} lpc_queue_stat_t;

	// weight of the symmetric sensor pair k, outermost pair first
	function automatic int pair_weight(input int k);
		int w;
		case (k)
			0: w = 350;
			1: w = 250;
			2: w = 150;
			default: w = 50;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/lpc_front.sv =====
`timescale 1ns / 1ps

module lpc_front import lpc_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int ENTRY_BITS    = 1 + (SAMPLE_BITS + 3) + (SAMPLE_BITS + 11)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [THRESH_BITS-1:0] line_threshold,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sensor [SENSOR_COUNT],
	input  lpc_queue_stat_t        qstat,
	output logic                   push,
	output logic [ENTRY_BITS-1:0]  push_data
);

	localparam int DW   = SAMPLE_BITS + 1;
	localparam int TW   = SAMPLE_BITS + 3;
	localparam int WSW  = SAMPLE_BITS + 11;
	localparam int CMPW = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

	logic [THRESH_BITS-1:0] thresh_q;

	logic [SAMPLE_BITS-1:0] qual_c [SENSOR_COUNT];
	logic [SENSOR_COUNT-1:0] hit_c;
	logic signed [DW-1:0] diff_c [PAIR_COUNT];
	logic [DW-1:0] pair_c [PAIR_COUNT];

	logic valid_s1, none_s1;
	logic signed [DW-1:0] diff_s1 [PAIR_COUNT];
	logic [DW-1:0] pair_s1 [PAIR_COUNT];

	logic signed [WSW-1:0] weighted_c;
	logic [TW-1:0] total_c;

	logic valid_s2, none_s2;
	logic signed [WSW-1:0] weighted_s2;
	logic [TW-1:0] total_s2;

	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			thresh_q <= line_threshold;
		end
	end

	always_comb begin
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			hit_c[i]  = CMPW'(sensor[i]) > CMPW'(thresh_q);
			qual_c[i] = hit_c[i] ? sensor[i] : '0;
		end
		// fold the symmetric weights: w*(right - left) per pair
		for (int k = 0; k < PAIR_COUNT; k++) begin
			diff_c[k] = $signed({1'b0, qual_c[SENSOR_COUNT-1-k]}) - $signed({1'b0, qual_c[k]});
			pair_c[k] = {1'b0, qual_c[SENSOR_COUNT-1-k]} + {1'b0, qual_c[k]};
		end
	end

	always_comb begin
		weighted_c = '0;
		total_c    = '0;
		for (int k = 0; k < PAIR_COUNT; k++) begin
			weighted_c = weighted_c + WSW'(diff_s1[k]) * $signed(WSW'(pair_weight(k)));
			total_c    = total_c + TW'(pair_s1[k]);
		end
	end

	// hold both stages while the queue is full and stage two has a word
	assign adv      = !(valid_s2 && qstat.full);
	assign in_ready = adv;
	assign push     = valid_s2 && !qstat.full;
	assign push_data = {none_s2, total_s2, weighted_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1     <= diff_c;
			pair_s1     <= pair_c;
			none_s1     <= ~|hit_c;
			weighted_s2 <= weighted_c;
			total_s2    <= total_c;
			none_s2     <= none_s1;
		end
	end

endmodule

// ===== hdl/lpc_queue.sv =====
`timescale 1ns / 1ps

module lpc_queue import lpc_pkg::*; #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output lpc_queue_stat_t  qstat
);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign qstat.full  = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/lpc_back.sv =====
`timescale 1ns / 1ps

module lpc_back import lpc_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int ENTRY_BITS    = 1 + (SAMPLE_BITS + 3) + (SAMPLE_BITS + 11)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ENTRY_BITS-1:0]      pop_data,
	input  lpc_queue_stat_t            qstat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [POS_BITS-1:0] line_position,
	output logic                       no_line
);

	localparam int TW  = SAMPLE_BITS + 3;
	localparam int WSW = SAMPLE_BITS + 11;
	localparam int MW  = SAMPLE_BITS + 10;
	localparam int NW  = MW + FRACTION_BITS;
	localparam int Q   = QUOT_INT_BITS + FRACTION_BITS;
	localparam int RW  = TW;
	localparam int CW  = ((Q > POS_BITS) ? Q : POS_BITS) + 1;

	logic signed [WSW-1:0] weighted_in, abs_in;
	logic [TW-1:0] total_in;
	logic none_in;
	logic [MW-1:0] mag_in;
	logic [NW-1:0] num_in;

	// divider stages; stage 0 takes the queue head, stage Q holds the quotient
	logic          vld_q  [Q+1];
	logic [RW-1:0] rem_q  [Q+1];
	logic [Q-1:0]  sh_q   [Q+1];
	logic [RW-1:0] div_q  [Q+1];
	logic          neg_q  [Q+1];
	logic          none_q [Q+1];

	logic out_valid_q, no_line_q;
	logic signed [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] pos_c;
	logic [CW-1:0] qx;
	logic adv;

	assign weighted_in = pop_data[WSW-1:0];
	assign total_in    = pop_data[WSW +: TW];
	assign none_in     = pop_data[ENTRY_BITS-1];
	assign abs_in      = weighted_in[WSW-1] ? -weighted_in : weighted_in;
	assign mag_in      = abs_in[MW-1:0];
	assign num_in      = NW'(mag_in) << FRACTION_BITS;

	// whole divider advances as one; stalls only behind a held result
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Q; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= !qstat.empty;
			for (int i = 1; i <= Q; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// quotient fits Q bits, so the top of the dividend is below the divisor
			rem_q[0]  <= RW'(num_in[NW-1:Q]);
			sh_q[0]   <= num_in[Q-1:0];
			div_q[0]  <= total_in;
			neg_q[0]  <= weighted_in[WSW-1];
			none_q[0] <= none_in;
		end
	end

	for (genvar i = 1; i <= Q; i++) begin : g_div
		logic [RW:0] trial, diff;
		logic ge;

		assign trial = {rem_q[i-1], sh_q[i-1][Q-1]};
		assign diff  = trial - {1'b0, div_q[i-1]};
		assign ge    = trial >= {1'b0, div_q[i-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
				// shift out one dividend bit, shift in one quotient bit
				sh_q[i]   <= {sh_q[i-1][Q-2:0], ge};
				div_q[i]  <= div_q[i-1];
				neg_q[i]  <= neg_q[i-1];
				none_q[i] <= none_q[i-1];
			end
		end
	end

	always_comb begin
		qx = CW'(sh_q[Q]);
		if (none_q[Q]) begin
			pos_c = '0;
		end else if (neg_q[Q]) begin
			if (qx > CW'(2 ** (POS_BITS - 1))) begin
				pos_c = {1'b1, {(POS_BITS - 1){1'b0}}};
			end else begin
				pos_c = POS_BITS'(-qx);
			end
		end else if (qx > CW'(2 ** (POS_BITS - 1) - 1)) begin
			pos_c = {1'b0, {(POS_BITS - 1){1'b1}}};
		end else begin
			pos_c = qx[POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[Q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q     <= $signed(pos_c);
			no_line_q <= none_q[Q];
		end
	end

	assign out_valid     = out_valid_q;
	assign line_position = pos_q;
	assign no_line       = no_line_q;

endmodule

// ===== hdl/line_position_centroid.sv =====
`timescale 1ns / 1ps
// Line position from eight reflectance samples by weighted centroid.
// Input channel (in_valid/in_ready) moves one word: sensor_0..sensor_7,
// left to right, weighted -350..+350. A sample strictly above the
// threshold register counts as on the line.
// Output channel (out_valid/out_ready) moves line_position, signed with
// FRACTION_BITS fraction bits, truncated toward zero, and no_line; with no
// qualifying sample the position is zero and no_line is set.
// Config channel (cfg_valid/cfg_ready) writes line_threshold; always ready.
// Throughput: one word per cycle while the output is not stalled. From
// input accept to output valid a word passes two front stages, the
// queue, and a divider retiring one quotient bit per stage.
// Reset clears all valid state and loads the threshold with 2048.
// A stalled receiver holds the output word and freezes the divider; the
// front keeps accepting until the four-entry queue between them is full.
module line_position_centroid import lpc_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [THRESH_BITS-1:0]     line_threshold,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [SAMPLE_BITS-1:0]     sensor_0,
	input  logic [SAMPLE_BITS-1:0]     sensor_1,
	input  logic [SAMPLE_BITS-1:0]     sensor_2,
	input  logic [SAMPLE_BITS-1:0]     sensor_3,
	input  logic [SAMPLE_BITS-1:0]     sensor_4,
	input  logic [SAMPLE_BITS-1:0]     sensor_5,
	input  logic [SAMPLE_BITS-1:0]     sensor_6,
	input  logic [SAMPLE_BITS-1:0]     sensor_7,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [POS_BITS-1:0] line_position,
	output logic                       no_line
);

	localparam int ENTRY_BITS = 1 + (SAMPLE_BITS + 3) + (SAMPLE_BITS + 11);

	logic [SAMPLE_BITS-1:0] sensor [SENSOR_COUNT];
	lpc_queue_stat_t qstat;
	logic push, pop;
	logic [ENTRY_BITS-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;
	assign sensor[0] = sensor_0;
	assign sensor[1] = sensor_1;
	assign sensor[2] = sensor_2;
	assign sensor[3] = sensor_3;
	assign sensor[4] = sensor_4;
	assign sensor[5] = sensor_5;
	assign sensor[6] = sensor_6;
	assign sensor[7] = sensor_7;

	lpc_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.line_threshold (line_threshold),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sensor         (sensor),
		.qstat          (qstat),
		.push           (push),
		.push_data      (push_data)
	);

	lpc_queue #(
		.WIDTH (ENTRY_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	lpc_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.ENTRY_BITS    (ENTRY_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_data      (pop_data),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_position (line_position),
		.no_line       (no_line)
	);

endmodule

// ===== hdl/lpc_checker.sv =====
`timescale 1ns / 1ps

module lpc_checker import lpc_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [POS_BITS-1:0] line_position,
	input logic                       no_line
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_position) && $stable(no_line))
		else $error("output word changed while stalled");

	// a frame with no line reports a centered position
	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_line |-> line_position == '0)
		else $error("no_line set with nonzero position");

	// first edge out of reset: nothing pending, input open
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid && in_ready)
		else $error("block not empty after reset");

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.line_position (line_position),
	.no_line       (no_line)
);
